[hw/rtl/jtm_pkg.sv]
// ----------------------------------------------------------------------------
// jtm_pkg
// Shared types and constants for the JTAG TAP master shifter.
// ----------------------------------------------------------------------------
package jtm_pkg;

    // Field widths
    localparam int DATA_W  = 8;
    localparam int TICK_W  = 7;
    localparam int CNT_W   = 7;
    localparam int PAT_W   = 4;

    // Longest clock run in one command
    localparam int MAX_RUN_DEFAULT = 64;

    // Command codes
    typedef enum logic [2:0] {
        ACT_RESET      = 3'd0,
        ACT_GO_IDLE    = 3'd1,
        ACT_ENTER_IR   = 3'd2,
        ACT_ENTER_DR   = 3'd3,
        ACT_WRITE_BYTE = 3'd4,
        ACT_READ_BYTE  = 3'd5,
        ACT_READ_BIT   = 3'd6,
        ACT_CLOCK_RUN  = 3'd7
    } act_t;

    // Tracked TAP position
    typedef enum logic [1:0] {
        TAP_RESET    = 2'd0,
        TAP_IDLE     = 2'd1,
        TAP_SHIFT_IR = 2'd2,
        TAP_SHIFT_DR = 2'd3
    } tap_t;

    // Sequencer phase
    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TMS,
        PH_FLUSH,
        PH_DATA
    } phase_t;

    // Pulse counts
    localparam logic [CNT_W-1:0] CNT_RESET    = 7'd10;
    localparam logic [CNT_W-1:0] CNT_ONE      = 7'd1;
    localparam logic [CNT_W-1:0] CNT_EXIT     = 7'd3;
    localparam logic [CNT_W-1:0] CNT_ENTER_IR = 7'd4;
    localparam logic [CNT_W-1:0] CNT_ENTER_DR = 7'd3;
    localparam logic [CNT_W-1:0] CNT_IR_BITS  = 7'd7;
    localparam logic [CNT_W-1:0] CNT_BYTE     = 7'd8;

    // TMS patterns, first pulse in bit 0
    localparam logic [PAT_W-1:0] PAT_ALL_HIGH = 4'b1111;
    localparam logic [PAT_W-1:0] PAT_ALL_LOW  = 4'b0000;
    localparam logic [PAT_W-1:0] PAT_EXIT     = 4'b0011;
    localparam logic [PAT_W-1:0] PAT_ENTER_IR = 4'b0011;
    localparam logic [PAT_W-1:0] PAT_ENTER_DR = 4'b0001;

    // Control from sequencer to data shifter
    typedef struct packed {
        logic load;
        logic step;
    } shift_ctrl_t;

    // One TCK pulse as produced by the sequencer
    typedef struct packed {
        logic tms;
        logic tdi;
        logic taken;
        logic last;
    } pulse_t;

endpackage

[hw/rtl/jtag_tap_master_shifter.sv]
// The first TCK pulse of a command is formed once the sequencer leaves idle, then
// held in the output register. Throughput: one pulse per cycle while out_ready is
// high; pulses per command: reset 10, writes and reads up to 9, runs up to MAX_RUN.
// The single pulse sequencer takes a new command only after its last pulse.
// Reset: rst_n is asynchronous and active low; the TAP position returns to
// test logic reset, the held bit and TDI level clear, and the output empties.
// ----------------------------------------------------------------------------
// jtag_tap_master_shifter
// JTAG TAP master: expands each command into TCK pulses, each carrying
// TMS, TDI, the TDO sample flag and the read data assembled so far.
// ----------------------------------------------------------------------------
module jtag_tap_master_shifter #(
    parameter int MAX_RUN = jtm_pkg::MAX_RUN_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 action,
    input  logic [jtm_pkg::DATA_W-1:0] data_in,
    input  logic [jtm_pkg::DATA_W-1:0] tdo_bits,
    input  logic [jtm_pkg::TICK_W-1:0] tick_count,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       tms,
    output logic                       tdi,
    output logic                       tdo_taken,
    output logic [jtm_pkg::DATA_W-1:0] read_data,
    output logic                       last
);
    import jtm_pkg::*;

    shift_ctrl_t        ctrl;
    pulse_t             pulse;
    logic               emit;
    logic               adv;
    logic               data_bit;
    logic               data_next_bit;
    logic [DATA_W-1:0]  acc_new;

    logic               out_valid_reg;
    logic               tms_reg;
    logic               tdi_reg;
    logic               taken_reg;
    logic [DATA_W-1:0]  rdata_reg;
    logic               last_reg;

    // Output register frees up when empty or on a transfer
    assign adv = !out_valid_reg || out_ready;

    jtm_seq #(
        .MAX_RUN (MAX_RUN)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (act_t'(action)),
        .tdi_set       (data_in[0]),
        .tick_count    (tick_count),
        .adv           (adv),
        .data_bit      (data_bit),
        .data_next_bit (data_next_bit),
        .ctrl          (ctrl),
        .pulse         (pulse),
        .emit          (emit)
    );

    jtm_shift u_shift (
        .clk           (clk),
        .ctrl          (ctrl),
        .data_in       (data_in),
        .tdo_bits      (tdo_bits),
        .data_bit      (data_bit),
        .data_next_bit (data_next_bit),
        .acc_new       (acc_new)
    );

    // Hold valid until transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Capture the pulse payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            tms_reg   <= pulse.tms;
            tdi_reg   <= pulse.tdi;
            taken_reg <= pulse.taken;
            rdata_reg <= pulse.taken ? acc_new : '0;
            last_reg  <= pulse.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign tms       = tms_reg;
    assign tdi       = tdi_reg;
    assign tdo_taken = taken_reg;
    assign read_data = rdata_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    // A sampled pulse never moves the TAP
    a_taken_tms_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && tdo_taken) |-> !tms)
        else $error("sampled pulse with TMS high");

    // Pulses that sample nothing carry zero read data
    a_unsampled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !tdo_taken) |-> (read_data == '0))
        else $error("read data nonzero on unsampled pulse");

    // More pulses of this command follow, so no new command is taken
    a_busy_mid_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> !in_ready)
        else $error("command taken before last pulse");

    // Emitting the final pulse frees the sequencer
    a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && pulse.last) |=> in_ready)
        else $error("sequencer busy after final pulse");
`endif

endmodule

[hw/rtl/jtm_shift.sv]
// ----------------------------------------------------------------------------
// jtm_shift
// Bit-serial data path: shifts the write byte out and the TDO bits in,
// one bit per data pulse, and assembles read data LSB first.
// ----------------------------------------------------------------------------
module jtm_shift (
    input  logic                       clk,
    input  jtm_pkg::shift_ctrl_t       ctrl,
    input  logic [jtm_pkg::DATA_W-1:0] data_in,
    input  logic [jtm_pkg::DATA_W-1:0] tdo_bits,
    output logic                       data_bit,
    output logic                       data_next_bit,
    output logic [jtm_pkg::DATA_W-1:0] acc_new
);
    import jtm_pkg::*;

    logic [DATA_W-1:0] data_sr_reg;
    logic [DATA_W-1:0] tdo_sr_reg;
    logic [DATA_W-1:0] mask_reg;
    logic [DATA_W-1:0] acc_reg;

    // Merge the current TDO bit at the position marked by the one-hot mask
    assign acc_new       = acc_reg | (mask_reg & {DATA_W{tdo_sr_reg[0]}});
    assign data_bit      = data_sr_reg[0];
    assign data_next_bit = data_sr_reg[1];

    // Load on command transfer, advance one bit per data pulse
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            data_sr_reg <= data_in;
            tdo_sr_reg  <= tdo_bits;
            mask_reg    <= DATA_W'(1);
            acc_reg     <= '0;
        end
        else if (ctrl.step)
        begin
            data_sr_reg <= {1'b0, data_sr_reg[DATA_W-1:1]};
            tdo_sr_reg  <= {1'b0, tdo_sr_reg[DATA_W-1:1]};
            mask_reg    <= {mask_reg[DATA_W-2:0], 1'b0};
            acc_reg     <= acc_new;
        end
    end

endmodule

[hw/rtl/jtm_seq.sv]
// ----------------------------------------------------------------------------
// jtm_seq
// Command sequencer: tracks the TAP position, the held IR bit and the TDI
// level, and steps through the TMS, flush and data phases of a command.
// ----------------------------------------------------------------------------
module jtm_seq #(
    parameter int MAX_RUN = jtm_pkg::MAX_RUN_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  jtm_pkg::act_t              action,
    input  logic                       tdi_set,
    input  logic [jtm_pkg::TICK_W-1:0] tick_count,
    input  logic                       adv,
    input  logic                       data_bit,
    input  logic                       data_next_bit,
    output jtm_pkg::shift_ctrl_t       ctrl,
    output jtm_pkg::pulse_t            pulse,
    output logic                       emit
);
    import jtm_pkg::*;

    phase_t            phase_reg,   phase_next;
    tap_t              tap_reg,     tap_next;
    logic              pending_reg, pending_next;
    logic              held_reg,    held_next;
    logic              tdi_lvl_reg, tdi_lvl_next;
    logic [CNT_W-1:0]  cnt_reg,     cnt_next;
    logic [PAT_W-1:0]  pat_reg,     pat_next;
    logic              fill_reg,    fill_next;
    logic              write_reg,   write_next;
    logic              hold_reg,    hold_next;
    logic              accept;
    logic              cnt_last;

    assign in_ready = (phase_reg == PH_IDLE);
    assign accept   = in_valid && in_ready;
    assign cnt_last = (cnt_reg == CNT_ONE);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tap_reg     <= TAP_RESET;
            pending_reg <= 1'b0;
            held_reg    <= 1'b0;
            tdi_lvl_reg <= 1'b0;
            cnt_reg     <= '0;
            pat_reg     <= '0;
            fill_reg    <= 1'b0;
            write_reg   <= 1'b0;
            hold_reg    <= 1'b0;
        end
        else
        begin
            phase_reg   <= phase_next;
            tap_reg     <= tap_next;
            pending_reg <= pending_next;
            held_reg    <= held_next;
            tdi_lvl_reg <= tdi_lvl_next;
            cnt_reg     <= cnt_next;
            pat_reg     <= pat_next;
            fill_reg    <= fill_next;
            write_reg   <= write_next;
            hold_reg    <= hold_next;
        end
    end

    // Next state and pulse generation
    always_comb
    begin
        phase_next   = phase_reg;
        tap_next     = tap_reg;
        pending_next = pending_reg;
        held_next    = held_reg;
        tdi_lvl_next = tdi_lvl_reg;
        cnt_next     = cnt_reg;
        pat_next     = pat_reg;
        fill_next    = fill_reg;
        write_next   = write_reg;
        hold_next    = hold_reg;
        ctrl.load    = accept;
        ctrl.step    = 1'b0;
        emit         = 1'b0;
        pulse.tms    = 1'b0;
        pulse.tdi    = tdi_lvl_reg;
        pulse.taken  = 1'b0;
        pulse.last   = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (accept)
                begin
                    fill_next  = 1'b0;
                    write_next = 1'b0;
                    hold_next  = 1'b0;
                    case (action)
                        ACT_RESET:
                        begin
                            phase_next   = PH_TMS;
                            cnt_next     = CNT_RESET;
                            pat_next     = PAT_ALL_HIGH;
                            fill_next    = 1'b1;
                            tap_next     = TAP_RESET;
                            pending_next = 1'b0;
                        end
                        ACT_GO_IDLE:
                        begin
                            if (tap_reg == TAP_RESET)
                            begin
                                phase_next = PH_TMS;
                                cnt_next   = CNT_ONE;
                                pat_next   = PAT_ALL_LOW;
                            end
                            else if (tap_reg == TAP_SHIFT_IR || tap_reg == TAP_SHIFT_DR)
                            begin
                                // Shift a held IR bit together with the exit
                                if (tap_reg == TAP_SHIFT_IR && pending_reg)
                                begin
                                    tdi_lvl_next = held_reg;
                                    pending_next = 1'b0;
                                end
                                phase_next = PH_TMS;
                                cnt_next   = CNT_EXIT;
                                pat_next   = PAT_EXIT;
                            end
                            tap_next = TAP_IDLE;
                        end
                        ACT_ENTER_IR:
                        begin
                            if (tap_reg == TAP_IDLE)
                            begin
                                phase_next = PH_TMS;
                                cnt_next   = CNT_ENTER_IR;
                                pat_next   = PAT_ENTER_IR;
                                tap_next   = TAP_SHIFT_IR;
                            end
                        end
                        ACT_ENTER_DR:
                        begin
                            if (tap_reg == TAP_IDLE)
                            begin
                                phase_next = PH_TMS;
                                cnt_next   = CNT_ENTER_DR;
                                pat_next   = PAT_ENTER_DR;
                                tap_next   = TAP_SHIFT_DR;
                            end
                        end
                        ACT_WRITE_BYTE:
                        begin
                            write_next = 1'b1;
                            hold_next  = (tap_reg == TAP_SHIFT_IR);
                            cnt_next   = (tap_reg == TAP_SHIFT_IR) ? CNT_IR_BITS : CNT_BYTE;
                            phase_next = pending_reg ? PH_FLUSH : PH_DATA;
                        end
                        ACT_READ_BYTE:
                        begin
                            cnt_next   = CNT_BYTE;
                            phase_next = pending_reg ? PH_FLUSH : PH_DATA;
                        end
                        ACT_READ_BIT:
                        begin
                            cnt_next   = CNT_ONE;
                            phase_next = PH_DATA;
                        end
                        ACT_CLOCK_RUN:
                        begin
                            if (tick_count == '0)
                            begin
                                tdi_lvl_next = tdi_set;
                            end
                            else
                            begin
                                phase_next = PH_TMS;
                                pat_next   = PAT_ALL_LOW;
                                if (32'(tick_count) > MAX_RUN)
                                begin
                                    cnt_next = CNT_W'(MAX_RUN);
                                end
                                else
                                begin
                                    cnt_next = CNT_W'(tick_count);
                                end
                            end
                        end
                        default:
                        begin
                            phase_next = PH_IDLE;
                        end
                    endcase
                end
            end
            PH_TMS:
            begin
                if (adv)
                begin
                    emit       = 1'b1;
                    pulse.tms  = pat_reg[0];
                    pulse.last = cnt_last;
                    pat_next   = {fill_reg, pat_reg[PAT_W-1:1]};
                    cnt_next   = cnt_reg - CNT_ONE;
                    if (cnt_last)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
            end
            PH_FLUSH:
            begin
                // Shift the held IR bit on a pulse of its own
                if (adv)
                begin
                    emit         = 1'b1;
                    pulse.tdi    = held_reg;
                    tdi_lvl_next = held_reg;
                    pending_next = 1'b0;
                    phase_next   = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (adv)
                begin
                    emit        = 1'b1;
                    ctrl.step   = 1'b1;
                    pulse.taken = 1'b1;
                    pulse.last  = cnt_last;
                    if (write_reg)
                    begin
                        pulse.tdi    = data_bit;
                        tdi_lvl_next = data_bit;
                    end
                    cnt_next = cnt_reg - CNT_ONE;
                    if (cnt_last)
                    begin
                        phase_next = PH_IDLE;
                        // Hold back the eighth bit of an IR write
                        if (hold_reg)
                        begin
                            pending_next = 1'b1;
                            held_next    = data_next_bit;
                        end
                    end
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

endmodule

[dv/jtag_tap_master_shifter_test.sv]
// ----------------------------------------------------------------------------
// jtag_tap_master_shifter_test
// Self-checking bench for the JTAG TAP master shifter. A queue of commands
// feeds a clocked driver. On every command transfer a behavioral model of
// the TAP master predicts the TCK pulses that follow. A clocked monitor
// compares each pulse transfer, field by field, against the oldest
// prediction. Both handshakes idle at random. A directed pass comes first,
// then random, mostly well-formed shift sequences.
// ----------------------------------------------------------------------------
module jtag_tap_master_shifter_test;

    timeunit 1ns;
    timeprecision 1ps;

    import jtm_pkg::*;

    typedef struct {
        act_t       action;
        logic [7:0] data;
        logic [7:0] tdo;
        logic [6:0] ticks;
        bit         drain_first;
    } tap_cmd_t;

    typedef struct {
        logic       tms;
        logic       tdi;
        logic       taken;
        logic [7:0] rd;
        logic       last;
    } tck_pulse_t;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [2:0] action;
    logic [7:0] data_in;
    logic [7:0] tdo_bits;
    logic [6:0] tick_count;
    logic       out_valid;
    logic       out_ready;
    logic       tms;
    logic       tdi;
    logic       tdo_taken;
    logic [7:0] read_data;
    logic       last;

    tap_cmd_t   pending_cmds[$];
    tck_pulse_t expected_pulses[$];

    // Model state of the TAP master
    tap_t tap_pos;
    bit   held_pending;
    bit   held_value;
    bit   tdi_lvl;

    bit       in_fire;
    bit       calm;
    int       send_gap;
    int       ready_gap;
    int       mismatches;
    int       pulses_checked;
    int       cmds_accepted;
    int       act_hits[8];
    tap_cmd_t next_cmd;

    jtag_tap_master_shifter u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .action     (action),
        .data_in    (data_in),
        .tdo_bits   (tdo_bits),
        .tick_count (tick_count),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .tms        (tms),
        .tdi        (tdi),
        .tdo_taken  (tdo_taken),
        .read_data  (read_data),
        .last       (last)
    );

    // Toggle the clock every half period
    always #2 clk = ~clk;

    // Pick an idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Pick a run length: mostly short, some long, a few beyond the cap
    function automatic logic [6:0] pick_ticks();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 7'd0;
        if (r < 80)
            return 7'($urandom_range(1, 8));
        if (r < 93)
            return 7'($urandom_range(9, 64));
        return 7'($urandom_range(65, 127));
    endfunction

    function automatic void queue_cmd(act_t a, logic [7:0] d, logic [7:0] t,
                                      logic [6:0] k, bit drain);
        tap_cmd_t c;
        c.action      = a;
        c.data        = d;
        c.tdo         = t;
        c.ticks       = k;
        c.drain_first = drain;
        pending_cmds.push_back(c);
    endfunction

    // Queue one random shift-state command
    function automatic void queue_shift_op(bit drain);
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            queue_cmd(ACT_WRITE_BYTE, 8'($urandom), 8'($urandom), 7'($urandom), drain);
        else if (r < 60)
            queue_cmd(ACT_READ_BYTE, 8'($urandom), 8'($urandom), 7'($urandom), drain);
        else if (r < 80)
            queue_cmd(ACT_READ_BIT, 8'($urandom), 8'($urandom), 7'($urandom), drain);
        else
            queue_cmd(ACT_CLOCK_RUN, 8'($urandom), 8'($urandom), pick_ticks(), drain);
    endfunction

    function automatic void add_pulse(logic t, logic d, logic tk, logic [7:0] rd);
        tck_pulse_t p;
        p.tms   = t;
        p.tdi   = d;
        p.taken = tk;
        p.rd    = rd;
        p.last  = 1'b0;
        expected_pulses.push_back(p);
    endfunction

    // Expand one command into its TCK pulses and advance the model state
    function automatic void predict_pulses(tap_cmd_t c);
        int         start;
        int         nbits;
        int         run;
        logic [7:0] acc;
        start = expected_pulses.size();
        acc   = 8'h00;
        case (c.action)
            ACT_RESET:
            begin
                repeat (10) add_pulse(1'b1, tdi_lvl, 1'b0, 8'h00);
                tap_pos      = TAP_RESET;
                held_pending = 1'b0;
            end
            ACT_GO_IDLE:
            begin
                if (tap_pos == TAP_RESET)
                    add_pulse(1'b0, tdi_lvl, 1'b0, 8'h00);
                else if (tap_pos == TAP_SHIFT_IR || tap_pos == TAP_SHIFT_DR)
                begin
                    // Shift the held bit on the way out of Shift-IR
                    if (tap_pos == TAP_SHIFT_IR && held_pending)
                    begin
                        tdi_lvl      = held_value;
                        held_pending = 1'b0;
                    end
                    repeat (2) add_pulse(1'b1, tdi_lvl, 1'b0, 8'h00);
                    add_pulse(1'b0, tdi_lvl, 1'b0, 8'h00);
                end
                tap_pos = TAP_IDLE;
            end
            ACT_ENTER_IR:
            begin
                if (tap_pos == TAP_IDLE)
                begin
                    repeat (2) add_pulse(1'b1, tdi_lvl, 1'b0, 8'h00);
                    repeat (2) add_pulse(1'b0, tdi_lvl, 1'b0, 8'h00);
                    tap_pos = TAP_SHIFT_IR;
                end
            end
            ACT_ENTER_DR:
            begin
                if (tap_pos == TAP_IDLE)
                begin
                    add_pulse(1'b1, tdi_lvl, 1'b0, 8'h00);
                    repeat (2) add_pulse(1'b0, tdi_lvl, 1'b0, 8'h00);
                    tap_pos = TAP_SHIFT_DR;
                end
            end
            ACT_WRITE_BYTE, ACT_READ_BYTE:
            begin
                // Flush a held bit on its own unsampled pulse
                if (held_pending)
                begin
                    tdi_lvl      = held_value;
                    held_pending = 1'b0;
                    add_pulse(1'b0, tdi_lvl, 1'b0, 8'h00);
                end
                nbits = (c.action == ACT_WRITE_BYTE && tap_pos == TAP_SHIFT_IR) ? 7 : 8;
                for (int i = 0; i < nbits; i++)
                begin
                    if (c.action == ACT_WRITE_BYTE)
                        tdi_lvl = c.data[i];
                    acc[i] = c.tdo[i];
                    add_pulse(1'b0, tdi_lvl, 1'b1, acc);
                end
                if (nbits == 7)
                begin
                    held_pending = 1'b1;
                    held_value   = c.data[7];
                end
            end
            ACT_READ_BIT:
                add_pulse(1'b0, tdi_lvl, 1'b1, {7'd0, c.tdo[0]});
            default:
            begin
                if (c.ticks == 7'd0)
                    tdi_lvl = c.data[0];
                else
                begin
                    run = (c.ticks > MAX_RUN_DEFAULT) ? MAX_RUN_DEFAULT : int'(c.ticks);
                    repeat (run) add_pulse(1'b0, tdi_lvl, 1'b0, 8'h00);
                end
            end
        endcase
        if (expected_pulses.size() > start)
            expected_pulses[expected_pulses.size() - 1].last = 1'b1;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h (pulse %0d)",
                 $realtime, what, got, want, pulses_checked);
    endtask

    // Generate the directed pass and the random sequences
    initial
    begin : gen_stimulus
        int r;
        int n_random;
        // Directed: positions, extremes and corner cases
        queue_cmd(ACT_RESET,      8'h00, 8'h00, 7'd0,   1'b0);
        queue_cmd(ACT_ENTER_IR,   8'h00, 8'h00, 7'd0,   1'b0);  // wrong position
        queue_cmd(ACT_WRITE_BYTE, 8'hA5, 8'h5A, 7'd0,   1'b0);  // shift outside shift state
        queue_cmd(ACT_GO_IDLE,    8'h00, 8'h00, 7'd0,   1'b0);
        queue_cmd(ACT_GO_IDLE,    8'h00, 8'h00, 7'd0,   1'b0);  // already idle
        queue_cmd(ACT_CLOCK_RUN,  8'hFF, 8'h00, 7'd0,   1'b0);  // zero ticks sets TDI
        queue_cmd(ACT_CLOCK_RUN,  8'h00, 8'hFF, 7'd3,   1'b0);
        queue_cmd(ACT_CLOCK_RUN,  8'h00, 8'h00, 7'd127, 1'b0);  // saturated run
        queue_cmd(ACT_CLOCK_RUN,  8'h00, 8'h00, 7'd64,  1'b0);
        queue_cmd(ACT_ENTER_IR,   8'h00, 8'h00, 7'd0,   1'b1);
        queue_cmd(ACT_ENTER_DR,   8'h00, 8'h00, 7'd0,   1'b0);  // wrong position
        queue_cmd(ACT_WRITE_BYTE, 8'hFF, 8'hFF, 7'd0,   1'b0);  // short IR write
        queue_cmd(ACT_READ_BIT,   8'h00, 8'h01, 7'd0,   1'b0);
        queue_cmd(ACT_CLOCK_RUN,  8'h00, 8'h00, 7'd2,   1'b0);
        queue_cmd(ACT_WRITE_BYTE, 8'h00, 8'h00, 7'd0,   1'b0);
        queue_cmd(ACT_READ_BYTE,  8'hFF, 8'hAA, 7'd0,   1'b0);
        queue_cmd(ACT_WRITE_BYTE, 8'h80, 8'h7F, 7'd0,   1'b0);
        queue_cmd(ACT_GO_IDLE,    8'h00, 8'h00, 7'd0,   1'b0);  // held bit on exit
        queue_cmd(ACT_ENTER_DR,   8'h00, 8'h00, 7'd0,   1'b0);
        queue_cmd(ACT_WRITE_BYTE, 8'h00, 8'h55, 7'd0,   1'b0);
        queue_cmd(ACT_READ_BYTE,  8'h00, 8'hFF, 7'd0,   1'b0);
        queue_cmd(ACT_READ_BIT,   8'hFF, 8'hFE, 7'd0,   1'b0);
        queue_cmd(ACT_GO_IDLE,    8'h00, 8'h00, 7'd0,   1'b0);
        queue_cmd(ACT_ENTER_IR,   8'h00, 8'h00, 7'd0,   1'b0);
        queue_cmd(ACT_WRITE_BYTE, 8'h01, 8'h80, 7'd0,   1'b0);
        queue_cmd(ACT_RESET,      8'h00, 8'h00, 7'd0,   1'b0);  // drop held bit

        // Random: mostly enter, shift and leave, with noise and resets
        n_random = 0;
        while (n_random < 334)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                queue_cmd(act_t'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                          pick_ticks(), 1'b0);
                n_random++;
            end
            else if (r < 14)
            begin
                queue_cmd(ACT_RESET, 8'($urandom), 8'($urandom), 7'($urandom), 1'b0);
                n_random++;
            end
            else
            begin
                queue_cmd(ACT_GO_IDLE, 8'($urandom), 8'($urandom), 7'($urandom),
                          $urandom_range(0, 29) == 0);
                n_random++;
                queue_cmd($urandom_range(0, 1) ? ACT_ENTER_IR : ACT_ENTER_DR,
                          8'($urandom), 8'($urandom), 7'($urandom), 1'b0);
                n_random++;
                repeat ($urandom_range(1, 5))
                begin
                    queue_shift_op(1'b0);
                    n_random++;
                end
                if ($urandom_range(0, 3) != 0)
                begin
                    queue_cmd(ACT_GO_IDLE, 8'($urandom), 8'($urandom), 7'($urandom), 1'b0);
                    n_random++;
                end
            end
        end
    end

    // Drive commands at the falling edge; hold each until its transfer
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap = send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_cmds.size() != 0 &&
                     !(pending_cmds[0].drain_first && expected_pulses.size() != 0))
            begin
                next_cmd = pending_cmds.pop_front();
                action     <= next_cmd.action;
                data_in    <= next_cmd.data;
                tdo_bits   <= next_cmd.tdo;
                tick_count <= next_cmd.ticks;
                in_valid   <= 1'b1;
                if ($urandom_range(0, 39) == 0)
                    calm = !calm;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Drive the pulse-side ready with random stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (ready_gap > 0)
            begin
                ready_gap = ready_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    ready_gap = pick_gap();
            end
        end
    end

    // Predict on each command transfer, then check each pulse transfer
    always @(posedge clk)
    begin : monitor
        tck_pulse_t want;
        if (rst_n)
        begin
            in_fire = in_valid && in_ready;
            if (in_fire)
            begin
                next_cmd.action = act_t'(action);
                next_cmd.data   = data_in;
                next_cmd.tdo    = tdo_bits;
                next_cmd.ticks  = tick_count;
                cmds_accepted++;
                act_hits[action]++;
                predict_pulses(next_cmd);
            end
            if (out_valid && out_ready)
            begin
                if (expected_pulses.size() == 0)
                    report_mismatch("unexpected pulse", int'(tms), 0);
                else
                begin
                    want = expected_pulses.pop_front();
                    if (tms !== want.tms)
                        report_mismatch("tms", int'(tms), int'(want.tms));
                    if (tdi !== want.tdi)
                        report_mismatch("tdi", int'(tdi), int'(want.tdi));
                    if (tdo_taken !== want.taken)
                        report_mismatch("tdo_taken", int'(tdo_taken), int'(want.taken));
                    if (read_data !== want.rd)
                        report_mismatch("read_data", int'(read_data), int'(want.rd));
                    if (last !== want.last)
                        report_mismatch("last", int'(last), int'(want.last));
                    pulses_checked++;
                end
            end
        end
    end

    // Reset, wait for all traffic to drain, then report
    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_RESET;
        data_in      = 8'h00;
        tdo_bits     = 8'h00;
        tick_count   = 7'd0;
        out_ready    = 1'b0;
        tap_pos      = TAP_RESET;
        held_pending = 1'b0;
        held_value   = 1'b0;
        tdi_lvl      = 1'b0;
        in_fire      = 1'b0;
        calm         = 1'b0;
        send_gap     = 0;
        ready_gap    = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (pending_cmds.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_pulses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (expected_pulses.size() != 0)
            report_mismatch("pulses never seen", 0, expected_pulses.size());
        $display("Summary: %0d commands, %0d TCK pulses checked, %0d mismatches",
                 cmds_accepted, pulses_checked, mismatches);
        $display("Summary: reset %0d, idle %0d, ir %0d, dr %0d, wr %0d, rd %0d, bit %0d, run %0d",
                 act_hits[0], act_hits[1], act_hits[2], act_hits[3],
                 act_hits[4], act_hits[5], act_hits[6], act_hits[7]);
        if (mismatches == 0)
            $display("jtag_tap_master_shifter test passed");
        else
            $display("jtag_tap_master_shifter test failed");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #20_000_000;
        $display("Timeout: traffic did not drain");
        $display("jtag_tap_master_shifter test failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/jtm_pkg.sv
hw/rtl/jtm_shift.sv
hw/rtl/jtm_seq.sv
hw/rtl/jtag_tap_master_shifter.sv
dv/jtag_tap_master_shifter_test.sv
